/* hw/rtl/matrix_store_bilinear_sampler_macros.svh */
// Assertion macros shared by the sampler RTL.
// Plain text macros only; the files that assert include this header.
`ifndef MATRIX_STORE_BILINEAR_SAMPLER_MACROS_SVH
`define MATRIX_STORE_BILINEAR_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MSBS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MSBS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/msbs_pkg.sv */
// Shared types and constants of the matrix store bilinear sampler.
// No dependencies; imported by every module of the block.
package msbs_pkg;

  localparam int unsigned CFG_W       = 7;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned ROW_W       = 6;
  localparam int unsigned COL_W       = 6;
  localparam int unsigned IDX_W       = 12;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned DATA_W      = 32;

  localparam int unsigned TDATA_IN_W  = 88;
  localparam int unsigned TUSER_IN_W  = 3;
  localparam int unsigned TDATA_OUT_W = 32;
  localparam int unsigned TUSER_OUT_W = 1;

  localparam int unsigned ROW_LSB     = 0;
  localparam int unsigned COL_LSB     = ROW_LSB + ROW_W;
  localparam int unsigned IDX_LSB     = COL_LSB + COL_W;
  localparam int unsigned VAL_LSB     = IDX_LSB + IDX_W;
  localparam int unsigned RPOS_LSB    = VAL_LSB + VALUE_W;
  localparam int unsigned CPOS_LSB    = RPOS_LSB + POS_W;

  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam int unsigned DEFAULT_MAX_ROWS      = 64;
  localparam int unsigned DEFAULT_MAX_COLS      = 64;
  localparam int unsigned DEFAULT_POS_FRAC_BITS = 8;

  // Operation codes carried in the input tuser.
  localparam logic [OP_W-1:0] OP_WR_RC  = OP_W'(0);
  localparam logic [OP_W-1:0] OP_RD_RC  = OP_W'(1);
  localparam logic [OP_W-1:0] OP_WR_IDX = OP_W'(2);
  localparam logic [OP_W-1:0] OP_RD_IDX = OP_W'(3);
  localparam logic [OP_W-1:0] OP_SAMPLE = OP_W'(4);

  // Register indexes (byte address / 4).
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef enum logic [1:0] {
    RES_REJECT,
    RES_WRITE,
    RES_READ,
    RES_SAMPLE
  } res_kind_e;

  typedef struct packed {
    logic [CFG_W-1:0] num_rows;
    logic [CFG_W-1:0] num_cols;
  } msbs_cfg_t;

  typedef struct packed {
    logic       load_in;
    logic       div_start;
    logic       div_step;
    logic       mem_we;
    logic       mem_re;
    logic       use_corner;
    logic [1:0] corner;
    logic       cap;
    logic       lerp_h0;
    logic       lerp_h1;
    logic       lerp_v;
    logic       out_load;
    res_kind_e  res_kind;
  } msbs_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            rc_ok;
    logic            idx_ok;
    logic            pos_ok;
    logic            div_done;
  } msbs_sts_t;

endpackage

/* hw/rtl/msbs_regs.sv */
// APB register file holding the matrix shape (num_rows, num_cols).
// Depends on msbs_pkg.
module msbs_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [msbs_pkg::APB_ADDR_W-1:0]   paddr_i,
  input  logic [msbs_pkg::APB_DATA_W-1:0]   pwdata_i,
  output logic [msbs_pkg::APB_DATA_W-1:0]   prdata_o,
  output logic                              pready_o,
  output msbs_pkg::msbs_cfg_t               cfg_o
);
  import msbs_pkg::*;

  logic             wr_en;
  logic             reg_idx;
  logic [CFG_W-1:0] num_rows_q, num_cols_q;

  assign pready_o = 1'b1;
  assign reg_idx  = paddr_i[2];
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= '0;
      num_cols_q <= '0;
    end else if (wr_en) begin
      if (reg_idx == REG_NUM_ROWS) begin
        num_rows_q <= pwdata_i[CFG_W-1:0];
      end else begin
        num_cols_q <= pwdata_i[CFG_W-1:0];
      end
    end
  end

  assign prdata_o = (reg_idx == REG_NUM_COLS) ? APB_DATA_W'(num_cols_q)
                                              : APB_DATA_W'(num_rows_q);

  assign cfg_o.num_rows = num_rows_q;
  assign cfg_o.num_cols = num_cols_q;

endmodule

/* hw/rtl/msbs_dp.sv */
// Datapath: input hold registers, range checks, bit-serial index divider,
// single-port sample store, corner capture, two-step lerp and result register.
// Depends on msbs_pkg; driven by msbs_ctrl through msbs_cmd_t.
module msbs_dp #(
  parameter int unsigned MAX_ROWS      = msbs_pkg::DEFAULT_MAX_ROWS,
  parameter int unsigned MAX_COLS      = msbs_pkg::DEFAULT_MAX_COLS,
  parameter int unsigned POS_FRAC_BITS = msbs_pkg::DEFAULT_POS_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  msbs_pkg::msbs_cfg_t            cfg_i,
  input  msbs_pkg::msbs_cmd_t            cmd_i,
  output msbs_pkg::msbs_sts_t            sts_o,
  input  logic [msbs_pkg::OP_W-1:0]      op_i,
  input  logic [msbs_pkg::ROW_W-1:0]     row_i,
  input  logic [msbs_pkg::COL_W-1:0]     column_i,
  input  logic [msbs_pkg::IDX_W-1:0]     index_i,
  input  logic [msbs_pkg::VALUE_W-1:0]   value_i,
  input  logic [msbs_pkg::POS_W-1:0]     row_pos_i,
  input  logic [msbs_pkg::POS_W-1:0]     col_pos_i,
  output logic [msbs_pkg::DATA_W-1:0]    data_o,
  output logic                           ok_o
);
  import msbs_pkg::*;

  localparam int unsigned Depth   = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned F       = POS_FRAC_BITS;
  localparam int unsigned CfgMax  = (1 << CFG_W) - 1;
  localparam int unsigned RowCap  = (MAX_ROWS > CfgMax) ? CfgMax : MAX_ROWS;
  localparam int unsigned ColCap  = (MAX_COLS > CfgMax) ? CfgMax : MAX_COLS;
  localparam int unsigned PosCmpW = (CFG_W + F > POS_W) ? CFG_W + F : POS_W;
  localparam int unsigned DivCntW = $clog2(IDX_W + 1);
  localparam int unsigned HW      = DATA_W + F;        // horizontal lerp value
  localparam int unsigned P1W     = DATA_W + F + 2;
  localparam int unsigned AccW    = DATA_W + 2 * F;    // full bilinear sum
  localparam int unsigned P2W     = DATA_W + 2 * F + 2;

  // Input hold registers
  logic [OP_W-1:0]    op_q;
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  logic [IDX_W-1:0]   idx_q;
  logic [VALUE_W-1:0] value_q;
  logic [POS_W-1:0]   row_pos_q, col_pos_q;

  // Effective shape
  logic [CFG_W-1:0]   nr, nc;
  logic [2*CFG_W-1:0] n_elems;
  logic [PosCmpW-1:0] lim_r, lim_c, rp_u, cp_u;

  // Divider
  logic [CFG_W:0]     rem_q, div_trial;
  logic [IDX_W-1:0]   quot_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               div_ge;

  // Addressing
  logic [CFG_W-1:0]   rl, cl, rh, ch, sel_row, sel_col;
  logic [F-1:0]       frac_b, frac_a;
  logic [AddrW-1:0]   mem_addr;

  // Store and samples
  logic [DATA_W-1:0]  sample_store_q [Depth];
  logic [DATA_W-1:0]  rd_q;
  logic [DATA_W-1:0]  quad_q [4];

  // Interpolation
  logic [DATA_W-1:0]        lo, hi;
  logic signed [DATA_W:0]   d1;
  logic signed [P1W-1:0]    p1, lo_sh, h_full;
  logic signed [HW-1:0]     h0_q, h1_q;
  logic signed [HW:0]       d2;
  logic signed [P2W-1:0]    p2, h0_sh, acc_full;
  logic [AccW-1:0]          acc_q;

  logic [DATA_W-1:0]  data_q;
  logic               ok_q;

  // Shape above the store size saturates to the store size.
  assign nr = (cfg_i.num_rows > CFG_W'(RowCap)) ? CFG_W'(RowCap) : cfg_i.num_rows;
  assign nc = (cfg_i.num_cols > CFG_W'(ColCap)) ? CFG_W'(ColCap) : cfg_i.num_cols;
  assign n_elems = (2*CFG_W)'(nr) * (2*CFG_W)'(nc);

  assign lim_r = PosCmpW'(nr - CFG_W'(1)) << F;
  assign lim_c = PosCmpW'(nc - CFG_W'(1)) << F;
  assign rp_u  = PosCmpW'(row_pos_q[POS_W-2:0]);
  assign cp_u  = PosCmpW'(col_pos_q[POS_W-2:0]);

  assign sts_o.op       = op_q;
  assign sts_o.rc_ok    = (CFG_W'(row_q) < nr) && (CFG_W'(col_q) < nc);
  assign sts_o.idx_ok   = (2*CFG_W)'(idx_q) < n_elems;
  assign sts_o.pos_ok   = (nr != '0) && (nc != '0)
                          && !row_pos_q[POS_W-1] && !col_pos_q[POS_W-1]
                          && (rp_u <= lim_r) && (cp_u <= lim_c);
  assign sts_o.div_done = (div_cnt_q == '0);

  // Restoring division: index / num_rows, one quotient bit per step.
  assign div_trial = {rem_q[CFG_W-1:0], quot_q[IDX_W-1]};
  assign div_ge    = div_trial >= {1'b0, nr};

  // Corner coordinates of the sample position.
  assign frac_b = row_pos_q[F-1:0];
  assign frac_a = col_pos_q[F-1:0];
  assign rl = CFG_W'(row_pos_q[POS_W-2:0] >> F);
  assign cl = CFG_W'(col_pos_q[POS_W-2:0] >> F);
  assign rh = (frac_b != '0) ? rl + CFG_W'(1) : rl;
  assign ch = (frac_a != '0) ? cl + CFG_W'(1) : cl;

  always_comb begin
    if (cmd_i.use_corner) begin
      sel_row = cmd_i.corner[1] ? rh : rl;
      sel_col = cmd_i.corner[0] ? ch : cl;
    end else if (op_q[1]) begin
      // Index access: row is the remainder, column the quotient.
      sel_row = rem_q[CFG_W-1:0];
      sel_col = CFG_W'(quot_q);
    end else begin
      sel_row = CFG_W'(row_q);
      sel_col = CFG_W'(col_q);
    end
  end

  assign mem_addr = AddrW'(32'(sel_row) * 32'(MAX_COLS) + 32'(sel_col));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      sample_store_q[mem_addr] <= value_q;
    end
    if (cmd_i.mem_re) begin
      rd_q <= sample_store_q[mem_addr];
    end
  end

  // Horizontal lerp: lo*2^F + a*(hi - lo).
  assign lo     = cmd_i.lerp_h1 ? quad_q[2] : quad_q[0];
  assign hi     = cmd_i.lerp_h1 ? quad_q[3] : quad_q[1];
  assign d1     = $signed({hi[DATA_W-1], hi}) - $signed({lo[DATA_W-1], lo});
  assign p1     = P1W'(d1) * P1W'($signed({1'b0, frac_a}));
  assign lo_sh  = $signed({{(P1W-DATA_W){lo[DATA_W-1]}}, lo}) <<< F;
  assign h_full = lo_sh + p1;

  // Vertical lerp: h0*2^F + b*(h1 - h0).
  assign d2       = $signed({h1_q[HW-1], h1_q}) - $signed({h0_q[HW-1], h0_q});
  assign p2       = P2W'(d2) * P2W'($signed({1'b0, frac_b}));
  assign h0_sh    = $signed({{(P2W-HW){h0_q[HW-1]}}, h0_q}) <<< F;
  assign acc_full = h0_sh + p2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= DivCntW'(IDX_W);
    end else if (cmd_i.div_step && (div_cnt_q != '0)) begin
      div_cnt_q <= div_cnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q      <= op_i;
      row_q     <= row_i;
      col_q     <= column_i;
      idx_q     <= index_i;
      value_q   <= value_i;
      row_pos_q <= row_pos_i;
      col_pos_q <= col_pos_i;
    end
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      quot_q <= idx_q;
    end else if (cmd_i.div_step && (div_cnt_q != '0)) begin
      rem_q  <= div_ge ? div_trial - {1'b0, nr} : div_trial;
      quot_q <= {quot_q[IDX_W-2:0], div_ge};
    end
    if (cmd_i.cap) begin
      quad_q[3] <= rd_q;
      for (int i = 0; i < 3; i++) begin
        quad_q[i] <= quad_q[i+1];
      end
    end
    if (cmd_i.lerp_h0) begin
      h0_q <= h_full[HW-1:0];
    end
    if (cmd_i.lerp_h1) begin
      h1_q <= h_full[HW-1:0];
    end
    if (cmd_i.lerp_v) begin
      acc_q <= acc_full[AccW-1:0];
    end
    if (cmd_i.out_load) begin
      unique case (cmd_i.res_kind)
        RES_REJECT: begin
          data_q <= '0;
          ok_q   <= 1'b0;
        end
        RES_WRITE: begin
          data_q <= '0;
          ok_q   <= 1'b1;
        end
        RES_READ: begin
          data_q <= rd_q;
          ok_q   <= 1'b1;
        end
        RES_SAMPLE: begin
          data_q <= acc_q[AccW-1 -: DATA_W];
          ok_q   <= 1'b1;
        end
        default: begin
          data_q <= '0;
          ok_q   <= 1'b0;
        end
      endcase
    end
  end

  assign data_o = data_q;
  assign ok_o   = ok_q;

endmodule

/* hw/rtl/msbs_ctrl.sv */
// Controller: sequences decode, division, store accesses, interpolation and
// the output transfer. Depends on msbs_pkg and the assertion macro header.
`include "matrix_store_bilinear_sampler_macros.svh"

module msbs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  msbs_pkg::msbs_sts_t  sts_i,
  output msbs_pkg::msbs_cmd_t  cmd_o
);
  import msbs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_ACCESS,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4,
    ST_LERP0,
    ST_LERP1,
    ST_LERP2,
    ST_FINISH
  } state_e;

  state_e    state_q, state_d;
  res_kind_e res_kind_q, res_kind_d;
  logic      out_valid_q, out_valid_d;
  logic      is_write;

  assign is_write = (sts_i.op == OP_WR_RC) || (sts_i.op == OP_WR_IDX);

  always_comb begin
    state_d        = state_q;
    res_kind_d     = res_kind_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.res_kind = res_kind_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.op)
          OP_WR_RC, OP_RD_RC: begin
            state_d = sts_i.rc_ok ? ST_ACCESS : ST_FINISH;
          end
          OP_WR_IDX, OP_RD_IDX: begin
            cmd_o.div_start = sts_i.idx_ok;
            state_d         = sts_i.idx_ok ? ST_DIV : ST_FINISH;
          end
          OP_SAMPLE: begin
            state_d = sts_i.pos_ok ? ST_RD0 : ST_FINISH;
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
        res_kind_d = RES_REJECT;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd_o.mem_we = is_write;
        cmd_o.mem_re = !is_write;
        res_kind_d   = is_write ? RES_WRITE : RES_READ;
        state_d      = ST_FINISH;
      end
      ST_RD0: begin
        cmd_o.mem_re     = 1'b1;
        cmd_o.use_corner = 1'b1;
        cmd_o.corner     = 2'd0;
        state_d          = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.mem_re     = 1'b1;
        cmd_o.use_corner = 1'b1;
        cmd_o.corner     = 2'd1;
        cmd_o.cap        = 1'b1;
        state_d          = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.mem_re     = 1'b1;
        cmd_o.use_corner = 1'b1;
        cmd_o.corner     = 2'd2;
        cmd_o.cap        = 1'b1;
        state_d          = ST_RD3;
      end
      ST_RD3: begin
        cmd_o.mem_re     = 1'b1;
        cmd_o.use_corner = 1'b1;
        cmd_o.corner     = 2'd3;
        cmd_o.cap        = 1'b1;
        state_d          = ST_RD4;
      end
      ST_RD4: begin
        cmd_o.cap = 1'b1;
        state_d   = ST_LERP0;
      end
      ST_LERP0: begin
        cmd_o.lerp_h0 = 1'b1;
        state_d       = ST_LERP1;
      end
      ST_LERP1: begin
        cmd_o.lerp_h1 = 1'b1;
        state_d       = ST_LERP2;
      end
      ST_LERP2: begin
        cmd_o.lerp_v = 1'b1;
        res_kind_d   = RES_SAMPLE;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    priority if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_kind_q  <= RES_REJECT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_kind_q  <= res_kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `MSBS_ASSERT_IMP(a_load_slot_free, clk_i, rst_ni, cmd_o.out_load, !out_valid_q || out_ready_i, "result loaded over a pending result")
  `MSBS_ASSERT_IMP(a_write_only_for_write_ops, clk_i, rst_ni, cmd_o.mem_we, sts_i.op == OP_WR_RC || sts_i.op == OP_WR_IDX, "store written by a non-write operation")
  `MSBS_ASSERT_NXT(a_accept_to_decode, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_DECODE, "accepted item not decoded next cycle")
  `MSBS_ASSERT_NXT(a_div_holds, clk_i, rst_ni, state_q == ST_DIV && !sts_i.div_done, state_q == ST_DIV, "divider left before its last step")

endmodule

/* hw/rtl/matrix_store_bilinear_sampler.sv */
// Matrix store bilinear sampler: top level, ports and unpacking of the streams.
// Depends on msbs_pkg, msbs_regs, msbs_ctrl and msbs_dp.
//
// The block holds a MAX_ROWS x MAX_COLS store of Q16.16 samples in one
// single-port memory, of which num_rows x num_cols (APB registers at 0x0 and
// 0x4, saturated to the store size) are in use. Each input transfer is one
// operation and yields exactly one output transfer carrying data and an ok
// flag. Operations: write or read by row/column, write or read by
// column-major index (row = index mod num_rows, column = index div num_rows),
// and a bilinear sample at signed fixed-point positions with POS_FRAC_BITS
// fraction bits. Out-of-range accesses and positions return data 0, ok 0.
// One item is in flight at a time. A row/column read or write passes decode,
// the store access and the result hand-over; a rejected item goes from decode
// straight to the hand-over; an index access first runs a 12-step bit-serial
// divider to form row and column; a bilinear sample makes four reads through
// the single store port, then three lerp multiplies in sequence. A finished
// result sits in the output register while the next item is already accepted,
// so a slow consumer stalls the block only when a second result is ready. The
// store has no reset; an entry must be written before it is read or sampled.
// Change the shape registers only while no item is in flight.
module matrix_store_bilinear_sampler #(
  parameter int unsigned MAX_ROWS      = msbs_pkg::DEFAULT_MAX_ROWS,
  parameter int unsigned MAX_COLS      = msbs_pkg::DEFAULT_MAX_COLS,
  parameter int unsigned POS_FRAC_BITS = msbs_pkg::DEFAULT_POS_FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // row[5:0], column[11:6], index[23:12], value[55:24],
  // row_pos[71:56], col_pos[87:72]
  input  logic [msbs_pkg::TDATA_IN_W-1:0]    s_axis_tdata_i,
  // operation[2:0]
  input  logic [msbs_pkg::TUSER_IN_W-1:0]    s_axis_tuser_i,
  // Output stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // data[31:0]
  output logic [msbs_pkg::TDATA_OUT_W-1:0]   m_axis_tdata_o,
  // ok[0]
  output logic [msbs_pkg::TUSER_OUT_W-1:0]   m_axis_tuser_o,
  // Configuration
  input  logic                               psel_i,
  input  logic                               penable_i,
  input  logic                               pwrite_i,
  input  logic [msbs_pkg::APB_ADDR_W-1:0]    paddr_i,
  input  logic [msbs_pkg::APB_DATA_W-1:0]    pwdata_i,
  output logic [msbs_pkg::APB_DATA_W-1:0]    prdata_o,
  output logic                               pready_o
);
  import msbs_pkg::*;

  msbs_cfg_t         cfg;
  msbs_cmd_t         cmd;
  msbs_sts_t         sts;
  logic [DATA_W-1:0] res_data;
  logic              res_ok;

  msbs_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  msbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Unpack the input transfer straight into the datapath hold registers.
  msbs_dp #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_COLS      (MAX_COLS),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .op_i      (s_axis_tuser_i[OP_W-1:0]),
    .row_i     (s_axis_tdata_i[ROW_LSB +: ROW_W]),
    .column_i  (s_axis_tdata_i[COL_LSB +: COL_W]),
    .index_i   (s_axis_tdata_i[IDX_LSB +: IDX_W]),
    .value_i   (s_axis_tdata_i[VAL_LSB +: VALUE_W]),
    .row_pos_i (s_axis_tdata_i[RPOS_LSB +: POS_W]),
    .col_pos_i (s_axis_tdata_i[CPOS_LSB +: POS_W]),
    .data_o    (res_data),
    .ok_o      (res_ok)
  );

  assign m_axis_tdata_o = res_data;
  assign m_axis_tuser_o = res_ok;

endmodule

/* verif/tb_top.sv */
// Testbench for the matrix store bilinear sampler: stream and APB drivers, an output
// stall pattern, and a scoreboard that keeps its own copy of the shape and the store.
// Depends on msbs_pkg and the matrix_store_bilinear_sampler RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import msbs_pkg::*;

  localparam int unsigned STORE_ROWS = DEFAULT_MAX_ROWS;
  localparam int unsigned STORE_COLS = DEFAULT_MAX_COLS;
  localparam int unsigned FRAC = DEFAULT_POS_FRAC_BITS;
  localparam longint POS_ONE = longint'(1) << FRAC;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_W'(OP_SAMPLE + 1);
  localparam logic [OP_W-1:0] OP_UNUSED_HI = '1;
  // An index access is the slowest item, so this covers any item still in flight.
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [IDX_W-1:0]   index;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   row_pos;
    logic [POS_W-1:0]   col_pos;
  } sample_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              ok;
  } sample_res_t;

  typedef enum int unsigned {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } stall_mode_e;

  // Tracks the shape registers and the store contents, predicts one result per request.
  class sampler_scoreboard;
    logic [CFG_W-1:0]  rows_reg;
    logic [CFG_W-1:0]  cols_reg;
    logic [DATA_W-1:0] store [STORE_ROWS*STORE_COLS];
    bit                written [STORE_ROWS*STORE_COLS];
    sample_res_t       expected_results [$];
    int unsigned       mismatches;

    function new();
      rows_reg = '0;
      cols_reg = '0;
      mismatches = 0;
    endfunction

    // Shape values above the store size saturate to it.
    function int unsigned live_rows();
      return (rows_reg > STORE_ROWS) ? STORE_ROWS : rows_reg;
    endfunction

    function int unsigned live_cols();
      return (cols_reg > STORE_COLS) ? STORE_COLS : cols_reg;
    endfunction

    function void set_shape(logic reg_idx, logic [APB_DATA_W-1:0] wdata);
      if (reg_idx == REG_NUM_ROWS) rows_reg = wdata[CFG_W-1:0];
      else cols_reg = wdata[CFG_W-1:0];
    endfunction

    function bit is_written(int unsigned r, int unsigned c);
      return written[r*STORE_COLS + c];
    endfunction

    function void flag(string what, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
      mismatches++;
      if (mismatches <= 10) $display("ERROR %s: expected %h, got %h", what, exp_v, act_v);
    endfunction

    function longint stored_word(int unsigned r, int unsigned c);
      return longint'($signed(store[r*STORE_COLS + c]));
    endfunction

    // Weight the four neighbours by the fractions, sum exactly, floor-shift by 2*FRAC.
    function bit bilinear_at(logic [POS_W-1:0] rp_bits, logic [POS_W-1:0] cp_bits,
                             output logic [DATA_W-1:0] res);
      longint rp, cp, nr, nc, a, b, acc;
      int unsigned rl, cl, rh, ch;
      rp = longint'($signed(rp_bits));
      cp = longint'($signed(cp_bits));
      nr = live_rows();
      nc = live_cols();
      res = '0;
      if (nr == 0 || nc == 0 || rp < 0 || cp < 0) return 1'b0;
      if (rp > (nr - 1) * POS_ONE || cp > (nc - 1) * POS_ONE) return 1'b0;
      rl = rp >> FRAC;
      cl = cp >> FRAC;
      b = rp % POS_ONE;
      a = cp % POS_ONE;
      rh = (b != 0) ? rl + 1 : rl;
      ch = (a != 0) ? cl + 1 : cl;
      acc = stored_word(rl, cl) * ((POS_ONE - b) * (POS_ONE - a))
          + stored_word(rl, ch) * ((POS_ONE - b) * a)
          + stored_word(rh, cl) * (b * (POS_ONE - a))
          + stored_word(rh, ch) * (b * a);
      res = DATA_W'(acc >>> (2 * FRAC));
      return 1'b1;
    endfunction

    function void note_request(sample_req_t q);
      int unsigned nr, nc, r, c;
      bit hit, wr, pos_ok;
      logic [DATA_W-1:0] interp;
      sample_res_t res;
      nr = live_rows();
      nc = live_cols();
      r = q.row;
      c = q.col;
      hit = 1'b0;
      wr = 1'b0;
      res = '0;
      case (q.op)
        OP_WR_RC, OP_RD_RC: begin
          hit = (r < nr) && (c < nc);
          wr = (q.op == OP_WR_RC);
        end
        OP_WR_IDX, OP_RD_IDX: begin
          hit = (nr != 0) && (nc != 0) && (q.index < nr * nc);
          wr = (q.op == OP_WR_IDX);
          if (hit) begin
            r = q.index % nr;
            c = q.index / nr;
          end
        end
        OP_SAMPLE: begin
          pos_ok = bilinear_at(q.row_pos, q.col_pos, interp);
          res.ok = pos_ok;
          res.data = pos_ok ? interp : '0;
        end
        default: ;
      endcase
      if (hit) begin
        res.ok = 1'b1;
        if (wr) begin
          store[r*STORE_COLS + c] = q.value;
          written[r*STORE_COLS + c] = 1'b1;
        end else begin
          res.data = store[r*STORE_COLS + c];
        end
      end
      expected_results.push_back(res);
    endfunction

    function void check_response(logic [DATA_W-1:0] data, logic ok);
      sample_res_t want;
      if (expected_results.size() == 0) begin
        flag("result with nothing pending, data", '0, data);
        return;
      end
      want = expected_results.pop_front();
      if (data !== want.data) flag("data", want.data, data);
      if (ok !== want.ok) flag("ok", DATA_W'(want.ok), DATA_W'(ok));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [TDATA_IN_W-1:0]  s_data = '0;
  logic [TUSER_IN_W-1:0]  s_user = '0;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_data;
  logic [TUSER_OUT_W-1:0] m_user;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  sampler_scoreboard sb;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  stall_mode_e stall_mode = RX_OPEN;
  int unsigned mode_left = 0;
  int unsigned period = 2;
  int unsigned beat = 0;

  always #4 clk = ~clk;

  matrix_store_bilinear_sampler u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  // Output side: check every transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) sb.check_response(m_data, m_user[0]);
  end

  // Output stall pattern: switch between open, light, heavy and periodic stalls.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 160);
      period = $urandom_range(2, 9);
    end
    mode_left--;
    beat++;
    case (stall_mode)
      RX_OPEN:  m_ready <= 1'b1;
      RX_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: m_ready <= ($urandom_range(0, 3) == 0);
      default:  m_ready <= ((beat % period) == 0);
    endcase
  end

  // Watchdog: any transfer on either stream or the APB port restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one request; open a new burst after a random gap when the current one ends.
  // Valid is touched at most once per time step.
  task automatic send_item(sample_req_t q);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_valid <= 1'b0;
        s_data <= {$urandom, $urandom, $urandom};
        s_user <= $urandom;
        repeat (gap) @(posedge clk);
      end
    end
    s_valid <= 1'b1;
    s_data <= {q.col_pos, q.row_pos, q.value, q.index, q.col, q.row};
    s_user <= q.op;
    do @(posedge clk); while (!s_ready);
    sb.note_request(q);
    burst_left--;
  endtask

  task automatic issue(logic [OP_W-1:0] op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                       logic [IDX_W-1:0] index, logic [VALUE_W-1:0] value,
                       logic [POS_W-1:0] row_pos, logic [POS_W-1:0] col_pos);
    sample_req_t q;
    q = '{op, row, col, index, value, row_pos, col_pos};
    send_item(q);
  endtask

  task automatic stop_stream();
    s_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup phase, then access phase until pready; psel then idles low to keep psel edges apart.
  task automatic apb_access(bit wr, logic reg_idx, logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {reg_idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a shape register with junk in the unused upper bits, then read it back.
  task automatic write_shape_reg(logic reg_idx, logic [CFG_W-1:0] v);
    logic [APB_DATA_W-1:0] wdata, rdata;
    wdata = $urandom;
    wdata[CFG_W-1:0] = v;
    apb_access(1'b1, reg_idx, wdata, rdata);
    sb.set_shape(reg_idx, wdata);
    apb_access(1'b0, reg_idx, $urandom, rdata);
    if (rdata !== APB_DATA_W'(v)) sb.flag("register readback", APB_DATA_W'(v), rdata);
  endtask

  task automatic configure(int unsigned rows, int unsigned cols);
    stop_stream();
    wait_drained();
    write_shape_reg(REG_NUM_ROWS, CFG_W'(rows));
    write_shape_reg(REG_NUM_COLS, CFG_W'(cols));
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Position inside the shape: often on a grid line, sometimes on the far edge.
  function automatic logic [POS_W-1:0] pick_pos(int unsigned n);
    int unsigned top;
    top = (n - 1) * POS_ONE;
    case ($urandom_range(0, 7))
      0, 1:    return POS_W'($urandom_range(0, n - 1) * POS_ONE);
      2:       return POS_W'(top);
      default: return POS_W'($urandom_range(0, top));
    endcase
  endfunction

  // Mostly in-shape requests with random content; one in ten keeps row, column, index and positions raw.
  function automatic sample_req_t random_request(int unsigned nr, int unsigned nc);
    sample_req_t q;
    int unsigned pick;
    bit shaped;
    q = {$urandom, $urandom, $urandom};
    shaped = (nr != 0) && (nc != 0) && ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 20) q.op = OP_WR_RC;
    else if (pick < 40) q.op = OP_RD_RC;
    else if (pick < 52) q.op = OP_WR_IDX;
    else if (pick < 64) q.op = OP_RD_IDX;
    else if (pick < 97) q.op = OP_SAMPLE;
    else q.op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    q.value = random_value();
    if (shaped) begin
      q.row = $urandom_range(0, nr - 1);
      q.col = $urandom_range(0, nc - 1);
      q.index = $urandom_range(0, nr * nc - 1);
      q.row_pos = pick_pos(nr);
      q.col_pos = pick_pos(nc);
    end
    return q;
  endfunction

  // Store an element first if a read or sample would otherwise touch it unwritten.
  task automatic ensure_written(int unsigned r, int unsigned c);
    int unsigned nr;
    nr = sb.live_rows();
    if (!sb.is_written(r, c)) begin
      if ($urandom_range(0, 1) != 0)
        issue(OP_WR_RC, r, c, $urandom, random_value(), $urandom, $urandom);
      else
        issue(OP_WR_IDX, $urandom, $urandom, c * nr + r, random_value(), $urandom, $urandom);
    end
  endtask

  task automatic make_safe(sample_req_t q);
    int unsigned nr, nc, r, c, rh, ch;
    longint rp, cp;
    nr = sb.live_rows();
    nc = sb.live_cols();
    if (nr == 0 || nc == 0) return;
    case (q.op)
      OP_RD_RC: begin
        if (q.row < nr && q.col < nc) ensure_written(q.row, q.col);
      end
      OP_RD_IDX: begin
        if (q.index < nr * nc) ensure_written(q.index % nr, q.index / nr);
      end
      OP_SAMPLE: begin
        rp = longint'($signed(q.row_pos));
        cp = longint'($signed(q.col_pos));
        if (rp >= 0 && cp >= 0 && rp <= longint'(nr - 1) * POS_ONE &&
            cp <= longint'(nc - 1) * POS_ONE) begin
          r = rp >> FRAC;
          c = cp >> FRAC;
          rh = r + (q.row_pos[FRAC-1:0] != 0);
          ch = c + (q.col_pos[FRAC-1:0] != 0);
          ensure_written(r, c);
          ensure_written(r, ch);
          ensure_written(rh, c);
          ensure_written(rh, ch);
        end
      end
      default: ;
    endcase
  endtask

  task automatic run_phase(int unsigned rows, int unsigned cols, int unsigned count);
    sample_req_t q;
    configure(rows, cols);
    repeat (count) begin
      q = random_request(sb.live_rows(), sb.live_cols());
      make_safe(q);
      send_item(q);
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty shape: everything is rejected.
    configure(0, 0);
    issue(OP_WR_RC, 0, 0, $urandom, $urandom, $urandom, $urandom);
    issue(OP_RD_IDX, $urandom, $urandom, 0, $urandom, $urandom, $urandom);
    issue(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, 0, 0);

    // Two rows by three columns, filled by both addressing modes with extreme values.
    configure(2, 3);
    issue(OP_WR_RC, 0, 0, $urandom, 32'h8000_0000, $urandom, $urandom);
    issue(OP_WR_RC, 1, 2, $urandom, 32'h7FFF_FFFF, $urandom, $urandom);
    issue(OP_WR_IDX, $urandom, $urandom, 1, 32'h0001_8000, $urandom, $urandom);
    issue(OP_WR_IDX, $urandom, $urandom, 2, 32'hFFFF_0000, $urandom, $urandom);
    issue(OP_WR_IDX, $urandom, $urandom, 3, $urandom, $urandom, $urandom);
    issue(OP_WR_IDX, $urandom, $urandom, 4, 32'h0000_0000, $urandom, $urandom);
    issue(OP_RD_RC, 1, 2, $urandom, $urandom, $urandom, $urandom);
    issue(OP_RD_IDX, $urandom, $urandom, 0, $urandom, $urandom, $urandom);
    // Out-of-range accesses: row, column, index just past the shape, largest index.
    issue(OP_RD_RC, 2, 0, $urandom, $urandom, $urandom, $urandom);
    issue(OP_RD_RC, 0, 3, $urandom, $urandom, $urandom, $urandom);
    issue(OP_RD_IDX, $urandom, $urandom, 6, $urandom, $urandom, $urandom);
    issue(OP_RD_IDX, $urandom, $urandom, 12'hFFF, $urandom, $urandom, $urandom);
    // Samples on the corners, in between, then negative and past the last row/column.
    issue(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, 16'h0000, 16'h0000);
    issue(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, 16'h0100, 16'h0200);
    issue(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, 16'h0080, 16'h0180);
    issue(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, 16'h00FF, 16'h0001);
    issue(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, 16'h8000, 16'h0000);
    issue(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, 16'h0101, 16'h0000);
    issue(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, 16'h0000, 16'h0201);
    issue(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, 16'h7FFF, 16'h7FFF);
    // Unused operation codes.
    issue(OP_UNUSED_LO, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    issue(OP_UNUSED_HI, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);

    // Random phases over several shapes: single element, full store, saturated
    // registers, one row or one column, empty in one dimension, and random small ones.
    run_phase(1, 1, 30);
    run_phase(64, 64, 70);
    run_phase(127, 90, 50);
    run_phase(2, 9, 60);
    run_phase(1, 64, 50);
    run_phase(64, 1, 50);
    run_phase(0, 7, 15);
    run_phase(5, 0, 15);
    repeat (4) run_phase($urandom_range(1, 12), $urandom_range(1, 12), 75);

    stop_stream();
    wait_drained();
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/msbs_pkg.sv
hw/rtl/msbs_regs.sv
hw/rtl/msbs_dp.sv
hw/rtl/msbs_ctrl.sv
hw/rtl/matrix_store_bilinear_sampler.sv
verif/tb_top.sv
